@@ rtl/core/tcc_pkg.sv @@
// Shared constants and types for the tilt-compensated compass pipeline.
`default_nettype none
package tcc_pkg;

	// Field widths of the sensor and configuration channels.
	localparam int ACC_W      = 16;
	localparam int RAWM_W     = 20;
	localparam int GAIN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Corrected magnetometer axis, signed.
	localparam int MAG_W = 26;

	// CORDIC angle accumulator (centidegrees * 2^16) and rounded angle widths.
	localparam int ZW     = 33;
	localparam int ANG_OW = 17;
	localparam int CS_MAX = 24;

	// Sine and cosine width, Q30.
	localparam int TRIG_W = 32;

	localparam logic signed [ZW-1:0] Q90 = 33'sd589824000;
	localparam logic signed [TRIG_W-1:0] KINV_Q30 = 32'sd652032874;

	// Arctangent of 2^-i in accumulator units.
	localparam logic signed [31:0] ATAN_TAB [CS_MAX] = '{
		32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
		32'sd23437865, 32'sd11730358, 32'sd5866610, 32'sd2933484,
		32'sd1466764, 32'sd733385, 32'sd366693, 32'sd183346,
		32'sd91673, 32'sd45837, 32'sd22918, 32'sd11459,
		32'sd5730, 32'sd2865, 32'sd1432, 32'sd716,
		32'sd358, 32'sd179, 32'sd90, 32'sd45
	};

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFF_X  = 3'd0,
		CFG_OFF_Y  = 3'd1,
		CFG_OFF_Z  = 3'd2,
		CFG_GAIN_X = 3'd3,
		CFG_GAIN_Y = 3'd4,
		CFG_GAIN_Z = 3'd5
	} cfg_idx_t;

endpackage
`default_nettype wire

@@ rtl/core/tcc_if.sv @@
// Channel interfaces: sensor sample requests, heading results and register writes.
`default_nettype none
interface tcc_in_if import tcc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ACC_W-1:0]  accel_x;
	logic signed [ACC_W-1:0]  accel_y;
	logic signed [ACC_W-1:0]  accel_z;
	logic [RAWM_W-1:0]        mag_x;
	logic [RAWM_W-1:0]        mag_y;
	logic [RAWM_W-1:0]        mag_z;

	modport source(output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
		input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
		output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_cdeg;
	logic signed [14:0] pitch_cdeg;
	logic [14:0]        tilt_cdeg;
	logic [15:0]        heading_cdeg;

	modport source(output valid, roll_cdeg, pitch_cdeg, tilt_cdeg, heading_cdeg,
		input ready);
	modport sink(input valid, roll_cdeg, pitch_cdeg, tilt_cdeg, heading_cdeg,
		output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tcc_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with sideband.
`default_nettype none
module tcc_sqrt import tcc_pkg::*; #(
	parameter int IW = 48,
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic             valid_i,
	input  logic [IW-1:0]    rad_i,
	input  logic [SW-1:0]    side_i,
	output logic             valid_o,
	output logic [IW/2-1:0]  root_o,
	output logic [IW/2:0]    rem_o,
	output logic [SW-1:0]    side_o
);
	localparam int H = IW / 2;

	logic [IW-1:0] v_s  [H+1];
	logic [IW-1:0] r_s  [H+1];
	logic          vl_s [H+1];
	logic [SW-1:0] sd_s [H+1];
	logic [IW:0]   t_c  [H];

	// Trial value for each stage: current root plus the stage's bit.
	always_comb begin
		for (int i = 0; i < H; i++) begin
			t_c[i] = {1'b0, r_s[i]} + ((IW+1)'(1) << (IW - 2 - 2*i));
		end
	end

	// Remainder and root advance one bit per stage.
	always_ff @(posedge clk) begin
		if (ce) begin
			v_s[0]  <= rad_i;
			r_s[0]  <= '0;
			sd_s[0] <= side_i;
			for (int i = 0; i < H; i++) begin
				if ({1'b0, v_s[i]} >= t_c[i]) begin
					v_s[i+1] <= v_s[i] - t_c[i][IW-1:0];
					r_s[i+1] <= (r_s[i] >> 1) + (IW'(1) << (IW - 2 - 2*i));
				end else begin
					v_s[i+1] <= v_s[i];
					r_s[i+1] <= r_s[i] >> 1;
				end
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_s <= '{default: 1'b0};
		end else if (ce) begin
			vl_s[0] <= valid_i;
			for (int i = 0; i < H; i++) begin
				vl_s[i+1] <= vl_s[i];
			end
		end
	end

	assign valid_o = vl_s[H];
	assign root_o  = r_s[H][H-1:0];
	assign rem_o   = v_s[H][H:0];
	assign side_o  = sd_s[H];
endmodule
`default_nettype wire

@@ rtl/core/tcc_vec.sv @@
// Pipelined vectoring CORDIC: atan2(y, x) rounded to centidegrees, with sideband.
`default_nettype none
module tcc_vec import tcc_pkg::*; #(
	parameter int W   = 26,
	parameter int NST = 16,
	parameter int SW  = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ce,
	input  logic                     valid_i,
	input  logic signed [W-1:0]      x_i,
	input  logic signed [W-1:0]      y_i,
	input  logic [SW-1:0]            side_i,
	output logic                     valid_o,
	output logic signed [ANG_OW-1:0] ang_o,
	output logic [SW-1:0]            side_o
);
	localparam int XW = W + 2;

	logic signed [XW-1:0] x_s  [NST+1];
	logic signed [XW-1:0] y_s  [NST+1];
	logic signed [ZW-1:0] z_s  [NST+1];
	logic                 zr_s [NST+1];
	logic                 vl_s [NST+1];
	logic [SW-1:0]        sd_s [NST+1];

	logic signed [XW-1:0]     xe, ye, x0, y0;
	logic signed [ZW-1:0]     z0, zrnd;
	logic signed [ANG_OW-1:0] ang_q;
	logic                     vo_q;
	logic [SW-1:0]            so_q;

	// Fold the left half plane into the right by a quarter turn.
	always_comb begin
		xe = XW'(x_i);
		ye = XW'(y_i);
		x0 = xe;
		y0 = ye;
		z0 = '0;
		if (xe[XW-1]) begin
			if (!ye[XW-1]) begin
				x0 = ye;
				y0 = -xe;
				z0 = Q90;
			end else begin
				x0 = -ye;
				y0 = xe;
				z0 = -Q90;
			end
		end
	end

	// Micro-rotations, one per stage, driving y toward zero.
	always_ff @(posedge clk) begin
		if (ce) begin
			x_s[0]  <= x0;
			y_s[0]  <= y0;
			z_s[0]  <= z0;
			zr_s[0] <= (x_i == '0) && (y_i == '0);
			sd_s[0] <= side_i;
			for (int i = 0; i < NST; i++) begin
				if (!y_s[i][XW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ZW'(ATAN_TAB[i]);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ZW'(ATAN_TAB[i]);
				end
				zr_s[i+1] <= zr_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	// Round the accumulator half up; a zero vector gives a zero angle.
	assign zrnd = z_s[NST] + ZW'(32768);

	always_ff @(posedge clk) begin
		if (ce) begin
			ang_q <= zr_s[NST] ? '0 : ANG_OW'(zrnd >>> 16);
			so_q  <= sd_s[NST];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_s <= '{default: 1'b0};
			vo_q <= 1'b0;
		end else if (ce) begin
			vl_s[0] <= valid_i;
			for (int i = 0; i < NST; i++) begin
				vl_s[i+1] <= vl_s[i];
			end
			vo_q <= vl_s[NST];
		end
	end

	assign valid_o = vo_q;
	assign ang_o   = ang_q;
	assign side_o  = so_q;
endmodule
`default_nettype wire

@@ rtl/core/tcc_rot.sv @@
// Pipelined rotation CORDIC: Q30 cosine and sine of two angles side by side.
`default_nettype none
module tcc_rot import tcc_pkg::*; #(
	parameter int NST = 16,
	parameter int SW  = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ce,
	input  logic                     valid_i,
	input  logic signed [15:0]       ang_i [2],
	input  logic [SW-1:0]            side_i,
	output logic                     valid_o,
	output logic signed [TRIG_W-1:0] cos_o [2],
	output logic signed [TRIG_W-1:0] sin_o [2],
	output logic [SW-1:0]            side_o
);
	logic signed [TRIG_W-1:0] x_s [2][NST+1];
	logic signed [TRIG_W-1:0] y_s [2][NST+1];
	logic signed [ZW-1:0]     z_s [2][NST+1];
	logic                     vl_s [NST+1];
	logic [SW-1:0]            sd_s [NST+1];

	logic signed [TRIG_W-1:0] x0 [2];
	logic signed [TRIG_W-1:0] y0 [2];
	logic signed [ZW-1:0]     z0 [2];

	// Start vector; angles beyond a quarter turn start from the vertical.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			z0[l] = ZW'(ang_i[l]) <<< 16;
			x0[l] = KINV_Q30;
			y0[l] = '0;
			if (ang_i[l] > 16'sd9000) begin
				x0[l] = '0;
				y0[l] = KINV_Q30;
				z0[l] = (ZW'(ang_i[l]) <<< 16) - Q90;
			end else if (ang_i[l] < -16'sd9000) begin
				x0[l] = '0;
				y0[l] = -KINV_Q30;
				z0[l] = (ZW'(ang_i[l]) <<< 16) + Q90;
			end
		end
	end

	// Micro-rotations, one per stage, driving the residual angle to zero.
	always_ff @(posedge clk) begin
		if (ce) begin
			sd_s[0] <= side_i;
			for (int i = 0; i < NST; i++) begin
				sd_s[i+1] <= sd_s[i];
			end
			for (int l = 0; l < 2; l++) begin
				x_s[l][0] <= x0[l];
				y_s[l][0] <= y0[l];
				z_s[l][0] <= z0[l];
				for (int i = 0; i < NST; i++) begin
					if (!z_s[l][i][ZW-1]) begin
						x_s[l][i+1] <= x_s[l][i] - (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] + (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] - ZW'(ATAN_TAB[i]);
					end else begin
						x_s[l][i+1] <= x_s[l][i] + (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] - (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] + ZW'(ATAN_TAB[i]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_s <= '{default: 1'b0};
		end else if (ce) begin
			vl_s[0] <= valid_i;
			for (int i = 0; i < NST; i++) begin
				vl_s[i+1] <= vl_s[i];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			cos_o[l] = x_s[l][NST];
			sin_o[l] = y_s[l][NST];
		end
	end

	assign valid_o = vl_s[NST];
	assign side_o  = sd_s[NST];
endmodule
`default_nettype wire

@@ rtl/core/tilt_compensated_compass_top.sv @@
// Tilt-compensated compass: roll, pitch, tilt and heading from one sensor sample.
// Usage:
//   in   - one request per sample: raw accelerometer X/Y/Z (signed) and raw
//          20-bit magnetometer X/Y/Z (centered at 2^19).
//   out  - one result per request, in order: roll, pitch, tilt and heading in
//          centidegrees, heading folded to 0..35999.
//   cfg  - register writes: index 0..2 hard-iron offsets, 3..5 Q4.12 gains.
//          Writes to other indexes are dropped. Write only while the
//          pipeline holds no request.
// Throughput: one request per cycle while the output is not stalled. The path
// runs through four CORDIC pipelines (roll, pitch, sine/cosine, heading)
// and two bit-per-stage square root pipelines, all in series.
// Reset clears every valid bit and loads offsets of 0 and gains of 1.0.
// When the receiver stalls a full output register, the whole pipeline holds
// and in.ready drops in the same cycle; nothing is dropped or repeated.
`default_nettype none
module tilt_compensated_compass_top import tcc_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input logic       clk,
	input logic       arst_n,
	tcc_in_if.sink    in,
	tcc_out_if.source out,
	tcc_cfg_if.sink   cfg
);
	localparam int NST  = (CORDIC_STAGES < CS_MAX) ? CORDIC_STAGES : CS_MAX;
	localparam int CW   = 22;
	localparam int PW   = 39;
	localparam int VW   = 26;
	localparam int LW   = 34;
	localparam int MPW  = MAG_W + TRIG_W;
	localparam int ZPW  = LW + TRIG_W;

	typedef struct packed {
		logic signed [ACC_W-1:0] ax, ay, az;
		logic signed [MAG_W-1:0] mx, my, mz;
	} sa_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] ax;
		logic [23:0]             rr;
		logic signed [MAG_W-1:0] mx, my, mz;
	} sb_t;

	typedef struct packed {
		logic signed [15:0]      roll;
		logic signed [MAG_W-1:0] mx, my, mz;
	} sc_t;

	typedef struct packed {
		logic signed [15:0]      roll;
		logic signed [14:0]      pitch;
		logic signed [MAG_W-1:0] mx, my, mz;
	} sd_t;

	typedef struct packed {
		logic signed [15:0]      roll;
		logic signed [14:0]      pitch;
		logic [14:0]             tilt;
		logic signed [MAG_W-1:0] mx, my, mz;
	} se_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic [14:0]        tilt;
	} sf_t;

	// Clamp a rounded CORDIC angle to +-lim.
	function automatic logic signed [ANG_OW-1:0] ang_clamp(
		input logic signed [ANG_OW-1:0] a,
		input logic signed [ANG_OW-1:0] lim
	);
		logic signed [ANG_OW-1:0] r;
		r = a;
		if (a > lim) r = lim;
		else if (a < -lim) r = -lim;
		return r;
	endfunction

	logic ce;

	// Configuration registers.
	logic signed [RAWM_W-1:0] off_x_q, off_y_q, off_z_q;
	logic [GAIN_W-1:0]        gain_x_q, gain_y_q, gain_z_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q  <= '0;
			off_y_q  <= '0;
			off_z_q  <= '0;
			gain_x_q <= GAIN_W'(4096);
			gain_y_q <= GAIN_W'(4096);
			gain_z_q <= GAIN_W'(4096);
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_OFF_X:  off_x_q  <= cfg.data;
				CFG_OFF_Y:  off_y_q  <= cfg.data;
				CFG_OFF_Z:  off_z_q  <= cfg.data;
				CFG_GAIN_X: gain_x_q <= cfg.data[GAIN_W-1:0];
				CFG_GAIN_Y: gain_y_q <= cfg.data[GAIN_W-1:0];
				CFG_GAIN_Z: gain_z_q <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: center and offset the magnetometer, apply gains, square ay and az.
	logic signed [CW-1:0]    cx, cy, cz;
	logic signed [PW-1:0]    px_s1, py_s1, pz_s1;
	logic [31:0]             ay2_s1, az2_s1;
	logic signed [ACC_W-1:0] ax_s1, ay_s1, az_s1;
	logic                    v_s1;

	assign cx = $signed({2'b00, in.mag_x}) - CW'(524288) - CW'(off_x_q);
	assign cy = $signed({2'b00, in.mag_y}) - CW'(524288) - CW'(off_y_q);
	assign cz = $signed({2'b00, in.mag_z}) - CW'(524288) - CW'(off_z_q);

	assign in.ready = ce;

	always_ff @(posedge clk) begin
		if (ce) begin
			px_s1  <= cx * $signed({1'b0, gain_x_q});
			py_s1  <= cy * $signed({1'b0, gain_y_q});
			pz_s1  <= cz * $signed({1'b0, gain_z_q});
			ay2_s1 <= 32'(in.accel_y * in.accel_y);
			az2_s1 <= 32'(in.accel_z * in.accel_z);
			ax_s1  <= in.accel_x;
			ay_s1  <= in.accel_y;
			az_s1  <= in.accel_z;
		end
	end

	// Pitch denominator: sqrt((ay^2 + az^2) * 2^16).
	sa_t sa_i, sa_o;
	logic        rv_v;
	logic [23:0] rr_root;

	assign sa_i.ax = ax_s1;
	assign sa_i.ay = ay_s1;
	assign sa_i.az = az_s1;
	assign sa_i.mx = MAG_W'(px_s1 >>> 12);
	assign sa_i.my = MAG_W'(py_s1 >>> 12);
	assign sa_i.mz = MAG_W'(pz_s1 >>> 12);

	tcc_sqrt #(.IW(48), .SW($bits(sa_t))) u_den_sqrt (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.valid_i(v_s1), .rad_i({32'(ay2_s1 + az2_s1), 16'h0000}), .side_i(sa_i),
		.valid_o(rv_v), .root_o(rr_root), .rem_o(), .side_o(sa_o)
	);

	// Roll = atan2(ay, az).
	sb_t sb_i, sb_o;
	logic                     roll_v;
	logic signed [ANG_OW-1:0] roll_a;

	assign sb_i.ax = sa_o.ax;
	assign sb_i.rr = rr_root;
	assign sb_i.mx = sa_o.mx;
	assign sb_i.my = sa_o.my;
	assign sb_i.mz = sa_o.mz;

	tcc_vec #(.W(VW), .NST(NST), .SW($bits(sb_t))) u_roll_vec (
		.clk(clk), .arst_n(arst_n), .ce(ce), .valid_i(rv_v),
		.x_i($signed({{2{sa_o.az[ACC_W-1]}}, sa_o.az, 8'h00})),
		.y_i($signed({{2{sa_o.ay[ACC_W-1]}}, sa_o.ay, 8'h00})),
		.side_i(sb_i),
		.valid_o(roll_v), .ang_o(roll_a), .side_o(sb_o)
	);

	// Pitch = atan2(-ax, rr).
	sc_t sc_i, sc_o;
	logic                     pit_v;
	logic signed [ANG_OW-1:0] pit_a;
	logic signed [VW-1:0]     pit_y;

	assign sc_i.roll = 16'(ang_clamp(roll_a, ANG_OW'(18000)));
	assign sc_i.mx   = sb_o.mx;
	assign sc_i.my   = sb_o.my;
	assign sc_i.mz   = sb_o.mz;
	assign pit_y     = -$signed({{2{sb_o.ax[ACC_W-1]}}, sb_o.ax, 8'h00});

	tcc_vec #(.W(VW), .NST(NST), .SW($bits(sc_t))) u_pitch_vec (
		.clk(clk), .arst_n(arst_n), .ce(ce), .valid_i(roll_v),
		.x_i($signed({2'b00, sb_o.rr})), .y_i(pit_y), .side_i(sc_i),
		.valid_o(pit_v), .ang_o(pit_a), .side_o(sc_o)
	);

	// Stage 2: clamp pitch and square both angles.
	logic signed [14:0]      pitch_c;
	sd_t                     sd_s2;
	logic [29:0]             rsq_s2, psq_s2;
	logic                    v_s2;

	assign pitch_c = 15'(ang_clamp(pit_a, ANG_OW'(9000)));

	always_ff @(posedge clk) begin
		if (ce) begin
			sd_s2.roll  <= sc_o.roll;
			sd_s2.pitch <= pitch_c;
			sd_s2.mx    <= sc_o.mx;
			sd_s2.my    <= sc_o.my;
			sd_s2.mz    <= sc_o.mz;
			rsq_s2      <= 30'(sc_o.roll * sc_o.roll);
			psq_s2      <= 30'(pitch_c * pitch_c);
		end
	end

	// Tilt: square root rounded to nearest.
	sd_t         sd_o;
	logic        tl_v;
	logic [14:0] tl_root;
	logic [15:0] tl_rem;
	se_t         se_i, se_o;

	tcc_sqrt #(.IW(30), .SW($bits(sd_t))) u_tilt_sqrt (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.valid_i(v_s2), .rad_i(rsq_s2 + psq_s2), .side_i(sd_s2),
		.valid_o(tl_v), .root_o(tl_root), .rem_o(tl_rem), .side_o(sd_o)
	);

	assign se_i.roll  = sd_o.roll;
	assign se_i.pitch = sd_o.pitch;
	assign se_i.tilt  = tl_root + 15'({1'b0, tl_root} < tl_rem);
	assign se_i.mx    = sd_o.mx;
	assign se_i.my    = sd_o.my;
	assign se_i.mz    = sd_o.mz;

	// Sine and cosine of roll (lane 0) and pitch (lane 1).
	logic signed [15:0]       rot_ang [2];
	logic signed [TRIG_W-1:0] rot_cos [2];
	logic signed [TRIG_W-1:0] rot_sin [2];
	logic                     rot_v;

	assign rot_ang[0] = sd_o.roll;
	assign rot_ang[1] = 16'(sd_o.pitch);

	tcc_rot #(.NST(NST), .SW($bits(se_t))) u_rot (
		.clk(clk), .arst_n(arst_n), .ce(ce), .valid_i(tl_v),
		.ang_i(rot_ang), .side_i(se_i),
		.valid_o(rot_v), .cos_o(rot_cos), .sin_o(rot_sin), .side_o(se_o)
	);

	// Stages 3 to 6: level the magnetometer vector.
	logic signed [MPW-1:0]    ycr_s3, zsr_s3, ysr_s3, zcr_s3, xcp_s3, xcp_s4, xcp_s5;
	logic signed [TRIG_W-1:0] sp_s3, sp_s4;
	logic signed [LW-1:0]     yh_s4, z1_s4, yh_s5, xh_s6, nyh_s6;
	logic signed [ZPW-1:0]    zsp_s5;
	logic signed [MPW:0]      ydif, zsum;
	logic signed [ZPW:0]      xsum;
	sf_t                      sf_s3, sf_s4, sf_s5, sf_s6;
	logic                     v_s3, v_s4, v_s5, v_s6;

	assign ydif = (MPW+1)'(ycr_s3) - (MPW+1)'(zsr_s3);
	assign zsum = (MPW+1)'(ysr_s3) + (MPW+1)'(zcr_s3);
	assign xsum = ((ZPW+1)'(xcp_s5) <<< 6) + (ZPW+1)'(zsp_s5);

	always_ff @(posedge clk) begin
		if (ce) begin
			ycr_s3 <= se_o.my * rot_cos[0];
			zsr_s3 <= se_o.mz * rot_sin[0];
			ysr_s3 <= se_o.my * rot_sin[0];
			zcr_s3 <= se_o.mz * rot_cos[0];
			xcp_s3 <= se_o.mx * rot_cos[1];
			sp_s3  <= rot_sin[1];
			sf_s3  <= '{roll: se_o.roll, pitch: se_o.pitch, tilt: se_o.tilt};

			yh_s4  <= LW'(ydif >>> 24);
			z1_s4  <= LW'(zsum >>> 24);
			xcp_s4 <= xcp_s3;
			sp_s4  <= sp_s3;
			sf_s4  <= sf_s3;

			zsp_s5 <= z1_s4 * sp_s4;
			xcp_s5 <= xcp_s4;
			yh_s5  <= yh_s4;
			sf_s5  <= sf_s4;

			xh_s6  <= LW'(xsum >>> 30);
			nyh_s6 <= -yh_s5;
			sf_s6  <= sf_s5;
		end
	end

	// Heading = atan2(-Yh, Xh).
	sf_t                      sf_o;
	logic                     hd_v;
	logic signed [ANG_OW-1:0] hd_a, hd_c, hd_f;

	tcc_vec #(.W(LW), .NST(NST), .SW($bits(sf_t))) u_head_vec (
		.clk(clk), .arst_n(arst_n), .ce(ce), .valid_i(v_s6),
		.x_i(xh_s6), .y_i(nyh_s6), .side_i(sf_s6),
		.valid_o(hd_v), .ang_o(hd_a), .side_o(sf_o)
	);

	// Fold the heading into 0..35999.
	always_comb begin
		hd_c = ang_clamp(hd_a, ANG_OW'(18000));
		hd_f = hd_c;
		if (hd_c[ANG_OW-1]) hd_f = hd_c + ANG_OW'(36000);
		if (hd_f >= ANG_OW'(36000)) hd_f = '0;
	end

	// Output register; the whole pipeline advances whenever it can drain.
	logic               out_v_q;
	logic signed [15:0] roll_q;
	logic signed [14:0] pitch_q;
	logic [14:0]        tilt_q;
	logic [15:0]        head_q;

	assign ce = !out_v_q || out.ready;

	always_ff @(posedge clk) begin
		if (ce) begin
			roll_q  <= sf_o.roll;
			pitch_q <= sf_o.pitch;
			tilt_q  <= sf_o.tilt;
			head_q  <= 16'(hd_f);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (ce) begin
			v_s1    <= in.valid;
			v_s2    <= pit_v;
			v_s3    <= rot_v;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			out_v_q <= hd_v;
		end
	end

	assign out.valid        = out_v_q;
	assign out.roll_cdeg    = roll_q;
	assign out.pitch_cdeg   = pitch_q;
	assign out.tilt_cdeg    = tilt_q;
	assign out.heading_cdeg = head_q;

	// Heading fold never lets a full turn through.
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> out.heading_cdeg < 16'd36000)
		else $error("heading out of range");

	// Pitch clamp holds at the output.
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> (out.pitch_cdeg <= 15'sd9000 && out.pitch_cdeg >= -15'sd9000))
		else $error("pitch out of range");

	// Zero tilt only when both roll and pitch are zero.
	a_tilt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.tilt_cdeg == 15'd0 |-> out.roll_cdeg == 16'sd0 &&
			out.pitch_cdeg == 15'sd0)
		else $error("tilt disagrees with roll and pitch");

	// Tilt never exceeds the magnitude of the two clamped angles.
	a_tilt_max: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> out.tilt_cdeg <= 15'd20125)
		else $error("tilt out of range");

	// A stalled output stage freezes the input side in the same cycle.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |-> !in.ready)
		else $error("input accepted while output stalled");
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the tilt-compensated compass pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb_top import tcc_pkg::*; ;

	localparam int STAGES     = 16;
	localparam int STAGES_USED = (STAGES < CS_MAX) ? STAGES : CS_MAX;
	localparam int DRAIN_CYC  = 4 * STAGES_USED + 55 + 40;
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = CFG_IDX_W'(CFG_GAIN_Z + 1);
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = CFG_IDX_W'(CFG_GAIN_Z + 2);
	localparam int MAG_CENTER = 524288;

	typedef struct packed {
		logic signed [ACC_W-1:0] ax;
		logic signed [ACC_W-1:0] ay;
		logic signed [ACC_W-1:0] az;
		logic [RAWM_W-1:0]       mx;
		logic [RAWM_W-1:0]       my;
		logic [RAWM_W-1:0]       mz;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic [14:0]        tilt;
		logic [15:0]        heading;
	} attitude_t;

	logic clk;
	logic arst_n;

	tcc_in_if  in_ch();
	tcc_out_if out_ch();
	tcc_cfg_if cfg_ch();

	tilt_compensated_compass_top #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source),
		.cfg(cfg_ch.sink)
	);

	// Calibration shadow of the block's registers.
	logic signed [19:0] cal_offset [3];
	logic [15:0]        cal_gain [3];

	attitude_t expected_q [$];
	int mismatches = 0;
	int results_seen = 0;
	int samples_sent = 0;
	int cfg_writes = 0;
	bit no_idle = 0;
	int stall_left = 0;

	// Clock.
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("Timeout after %0d results", results_seen);
		$display("Some tests failed");
		$finish;
	end

	// Integer square root, truncating.
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Vectoring CORDIC arctangent, result in centidegrees.
	function automatic longint atan2_cdeg(input longint y, input longint x);
		longint z, t;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 9000 * 65536;
			end else begin
				x = -y; y = t; z = -9000 * 65536;
			end
		end
		for (int i = 0; i < STAGES_USED; i++) begin
			t = x;
			if (y >= 0) begin
				x += y >>> i; y -= t >>> i; z += longint'(ATAN_TAB[i]);
			end else begin
				x -= y >>> i; y += t >>> i; z -= longint'(ATAN_TAB[i]);
			end
		end
		return (z + 32768) >>> 16;
	endfunction

	// Rotation CORDIC giving Q30 cosine and sine of a centidegree angle.
	function automatic void sin_cos_q30(input longint cdeg, output longint c,
			output longint s);
		longint x, y, z, t;
		x = longint'(KINV_Q30);
		y = 0;
		z = cdeg * 65536;
		if (cdeg > 9000) begin
			x = 0; y = longint'(KINV_Q30); z -= 9000 * 65536;
		end else if (cdeg < -9000) begin
			x = 0; y = -longint'(KINV_Q30); z += 9000 * 65536;
		end
		for (int i = 0; i < STAGES_USED; i++) begin
			t = x;
			if (z >= 0) begin
				x -= y >>> i; y += t >>> i; z -= longint'(ATAN_TAB[i]);
			end else begin
				x += y >>> i; y -= t >>> i; z += longint'(ATAN_TAB[i]);
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint clip(input longint v, input longint lim);
		return (v < -lim) ? -lim : ((v > lim) ? lim : v);
	endfunction

	// Corrected magnetometer axis: centered, offset removed, gain applied.
	function automatic longint mag_axis(input logic [RAWM_W-1:0] raw, input int a);
		longint c;
		c = longint'(raw) - MAG_CENTER - longint'(cal_offset[a]);
		return (c * longint'(cal_gain[a])) >>> 12;
	endfunction

	// Full attitude and heading computation for one sample.
	function automatic attitude_t compute_attitude(input sample_t smp);
		longint ax, ay, az, mx, my, mz, roll, pitch, head, rr;
		longint cr, sr, cp, sp, yh, z1, xh;
		longint unsigned sq, r;
		attitude_t res;
		ax = smp.ax; ay = smp.ay; az = smp.az;
		mx = mag_axis(smp.mx, 0);
		my = mag_axis(smp.my, 1);
		mz = mag_axis(smp.mz, 2);
		roll = clip(atan2_cdeg(ay * 256, az * 256), 18000);
		rr = longint'(int_sqrt(longint'(ay * ay + az * az) << 16));
		pitch = clip(atan2_cdeg(-ax * 256, rr), 9000);
		sq = roll * roll + pitch * pitch;
		r = int_sqrt(sq);
		if (sq - r * r > r)
			r++;
		sin_cos_q30(roll, cr, sr);
		sin_cos_q30(pitch, cp, sp);
		yh = (my * cr - mz * sr) >>> 24;
		z1 = (my * sr + mz * cr) >>> 24;
		xh = (mx * 64 * cp + z1 * sp) >>> 30;
		head = clip(atan2_cdeg(-yh, xh), 18000);
		if (head < 0)
			head += 36000;
		if (head >= 36000)
			head = 0;
		res.roll = roll[15:0];
		res.pitch = pitch[14:0];
		res.tilt = r[14:0];
		res.heading = head[15:0];
		return res;
	endfunction

	// Send one sample request and record its expected attitude on acceptance.
	task automatic send_sample(input sample_t smp);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.accel_x <= smp.ax;
		in_ch.accel_y <= smp.ay;
		in_ch.accel_z <= smp.az;
		in_ch.mag_x <= smp.mx;
		in_ch.mag_y <= smp.my;
		in_ch.mag_z <= smp.mz;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		expected_q.push_back(compute_attitude(smp));
		samples_sent++;
	endtask

	task automatic end_of_stream();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every expected result has arrived, then let the pipeline empty.
	task automatic drain();
		end_of_stream();
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// Register write; only called while the pipeline is empty.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_OFF_X:  cal_offset[0] = val;
			CFG_OFF_Y:  cal_offset[1] = val;
			CFG_OFF_Z:  cal_offset[2] = val;
			CFG_GAIN_X: cal_gain[0] = val[15:0];
			CFG_GAIN_Y: cal_gain[1] = val[15:0];
			CFG_GAIN_Z: cal_gain[2] = val[15:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic write_all(input logic [CFG_DATA_W-1:0] ox, oy, oz, gx, gy, gz);
		write_reg(CFG_OFF_X, ox);
		write_reg(CFG_OFF_Y, oy);
		write_reg(CFG_OFF_Z, oz);
		write_reg(CFG_GAIN_X, gx);
		write_reg(CFG_GAIN_Y, gy);
		write_reg(CFG_GAIN_Z, gz);
	endtask

	function automatic sample_t random_sample();
		sample_t smp;
		int mode;
		mode = $urandom_range(0, 3);
		smp.mx = RAWM_W'($urandom);
		smp.my = RAWM_W'($urandom);
		smp.mz = RAWM_W'($urandom);
		if (mode == 0) begin
			// Small tilts near level with gravity on Z.
			smp.ax = ACC_W'($signed($urandom_range(0, 8000)) - 4000);
			smp.ay = ACC_W'($signed($urandom_range(0, 8000)) - 4000);
			smp.az = ACC_W'($urandom_range(12000, 20000));
			// Field of realistic size around the center.
			smp.mx = RAWM_W'(MAG_CENTER + $signed($urandom_range(0, 20000)) - 10000);
			smp.my = RAWM_W'(MAG_CENTER + $signed($urandom_range(0, 20000)) - 10000);
			smp.mz = RAWM_W'(MAG_CENTER + $signed($urandom_range(0, 20000)) - 10000);
		end else begin
			smp.ax = ACC_W'($urandom);
			smp.ay = ACC_W'($urandom);
			smp.az = ACC_W'($urandom);
		end
		return smp;
	endfunction

	task automatic mk_send(input int ax, ay, az, input int mx, my, mz);
		sample_t smp;
		smp.ax = ACC_W'(ax); smp.ay = ACC_W'(ay); smp.az = ACC_W'(az);
		smp.mx = RAWM_W'(mx); smp.my = RAWM_W'(my); smp.mz = RAWM_W'(mz);
		send_sample(smp);
	endtask

	// Directed samples: zero vectors, extremes, every quadrant and the heading wrap.
	task automatic test_directed();
		mk_send(0, 0, 0, MAG_CENTER, MAG_CENTER, MAG_CENTER);
		mk_send(0, 0, 16384, MAG_CENTER + 1000, MAG_CENTER, MAG_CENTER);
		mk_send(0, 0, 16384, MAG_CENTER - 1000, MAG_CENTER, MAG_CENTER);
		mk_send(0, 0, 16384, MAG_CENTER, MAG_CENTER + 1000, MAG_CENTER);
		mk_send(0, 0, 16384, MAG_CENTER, MAG_CENTER - 1000, MAG_CENTER);
		mk_send(0, 0, 16384, MAG_CENTER + 1000, MAG_CENTER - 1, MAG_CENTER);
		mk_send(0, 0, 16384, MAG_CENTER + 1000, MAG_CENTER + 1, MAG_CENTER);
		mk_send(-32768, -32768, -32768, 0, 0, 0);
		mk_send(32767, 32767, 32767, 1048575, 1048575, 1048575);
		mk_send(-32768, 0, 0, 0, 1048575, 0);
		mk_send(32767, 0, 0, 1048575, 0, 1048575);
		mk_send(0, 0, -16384, MAG_CENTER + 500, MAG_CENTER + 300, MAG_CENTER - 200);
		mk_send(0, 16384, 0, MAG_CENTER + 500, MAG_CENTER + 300, MAG_CENTER - 200);
		mk_send(0, -16384, 0, MAG_CENTER - 500, MAG_CENTER + 300, MAG_CENTER + 200);
		mk_send(0, 100, -16384, MAG_CENTER, MAG_CENTER, MAG_CENTER + 700);
		mk_send(0, -100, -16384, MAG_CENTER, MAG_CENTER, MAG_CENTER + 700);
		mk_send(8000, 5000, 12000, MAG_CENTER + 300, MAG_CENTER - 800, MAG_CENTER + 400);
		mk_send(-8000, -5000, 12000, MAG_CENTER - 300, MAG_CENTER + 800, MAG_CENTER - 400);
		mk_send(1, -1, 1, MAG_CENTER + 1, MAG_CENTER - 1, MAG_CENTER + 1);
		mk_send(-1, 1, -1, MAG_CENTER - 1, MAG_CENTER + 1, MAG_CENTER - 1);
	endtask

	task automatic test_random(input int count);
		for (int k = 0; k < count; k++) begin
			// Stretches with no idling on either side.
			if (k % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			send_sample(random_sample());
		end
		no_idle = 0;
	endtask

	// Extreme calibration and unmapped register indexes.
	task automatic test_cal_extremes();
		drain();
		write_all(20'h80000, 20'h7FFFF, 20'h80000, 20'hF0000, 20'hFFFFF, 20'h00000);
		write_reg(IDX_UNMAPPED_LO, 20'h12345);
		write_reg(IDX_UNMAPPED_HI, 20'hFFFFF);
		test_random(100);
		drain();
		write_all(20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h0FFFF, 20'h00000, 20'hFFFFF);
		test_random(100);
	endtask

	task automatic test_cal_random();
		for (int ph = 0; ph < 3; ph++) begin
			drain();
			write_all(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
				CFG_DATA_W'($urandom_range(2048, 8192)),
				CFG_DATA_W'($urandom_range(2048, 8192)), CFG_DATA_W'($urandom));
			test_random(80);
		end
		drain();
		write_all(20'd0, 20'd0, 20'd0, 20'd4096, 20'd4096, 20'd4096);
		test_directed();
	endtask

	// Result checking and receiver stalls.
	always @(posedge clk) begin
		attitude_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: roll %0d pitch %0d tilt %0d heading %0d",
						out_ch.roll_cdeg, out_ch.pitch_cdeg, out_ch.tilt_cdeg,
						out_ch.heading_cdeg);
			end else begin
				exp_r = expected_q.pop_front();
				if (out_ch.roll_cdeg !== exp_r.roll || out_ch.pitch_cdeg !== exp_r.pitch
						|| out_ch.tilt_cdeg !== exp_r.tilt
						|| out_ch.heading_cdeg !== exp_r.heading) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
							results_seen, exp_r.roll, exp_r.pitch, exp_r.tilt,
							exp_r.heading, out_ch.roll_cdeg, out_ch.pitch_cdeg,
							out_ch.tilt_cdeg, out_ch.heading_cdeg);
				end
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 14);
		end
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Test sequence.
	initial begin
		in_ch.valid = 1'b0;
		in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
		in_ch.mag_x = '0; in_ch.mag_y = '0; in_ch.mag_z = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_OFF_X;
		cfg_ch.data = '0;
		for (int a = 0; a < 3; a++) begin
			cal_offset[a] = '0;
			cal_gain[a] = 16'd4096;
		end
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(150);
		test_cal_extremes();
		test_cal_random();
		drain();

		$display("Covered %0d samples and %0d register writes, %0d results checked.",
			samples_sent, cfg_writes, results_seen);
		$display("Calibration ran at reset, extreme and random settings with random stalls.");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/tcc_pkg.sv
rtl/core/tcc_if.sv
rtl/core/tcc_sqrt.sv
rtl/core/tcc_vec.sv
rtl/core/tcc_rot.sv
rtl/core/tilt_compensated_compass_top.sv
tb/tb_top.sv
